### src/tpwe_pkg.sv
// shared types and constants for the tape pulse-width encoder
// no dependencies; used by tpwe_core and tape_pulse_width_encoder_top
package tpwe_pkg;

    localparam int unsigned PULSE_W = 16;
    localparam int unsigned COUNT_W = 10;
    localparam int unsigned ACC_W   = 24;
    localparam int unsigned TGT_W   = 17;
    localparam int unsigned ELAP_W  = 12;

    // configuration register indexes
    localparam logic [1:0] CFG_SHORT_PULSE = 2'd0;
    localparam logic [1:0] CFG_LONG_PULSE  = 2'd1;
    localparam logic [1:0] CFG_LEADER_BITS = 2'd2;
    localparam logic [1:0] CFG_TRAILER_BITS = 2'd3;

    localparam logic [PULSE_W-1:0] SHORT_PULSE_RST  = 16'd208;
    localparam logic [PULSE_W-1:0] LONG_PULSE_RST   = 16'd416;
    localparam logic [COUNT_W-1:0] LEADER_BITS_RST  = 10'd510;
    localparam logic [COUNT_W-1:0] TRAILER_BITS_RST = 10'd128;

    localparam logic [7:0]         SYNC_BYTE = 8'h55;
    localparam logic [COUNT_W-1:0] BYTE_BITS = 10'd9;   // start bit plus eight data bits

    typedef struct packed {
        logic [PULSE_W-1:0] short_pulse_ticks;
        logic [PULSE_W-1:0] long_pulse_ticks;
        logic [COUNT_W-1:0] leader_bit_count;
        logic [COUNT_W-1:0] trailer_bit_count;
    } cfg_t;

    typedef struct packed {
        logic        kind;
        logic [11:0] elapsed_ticks;
        logic [7:0]  next_byte;
        logic [15:0] block_length;
        logic        is_header;
    } item_t;

    typedef struct packed {
        logic busy_res;
        logic next_block_request;
        logic progress_pulse;
        logic byte_taken;
        logic tape_level;
    } result_t;

endpackage

### src/tpwe_core.sv
// encoder state machine: one step per accepted beat, result registered
// depends on tpwe_pkg
module tpwe_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step_en,
    input  tpwe_pkg::item_t   item,
    input  tpwe_pkg::cfg_t    cfg,
    output tpwe_pkg::result_t result
);

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_LEADER    = 4'd1,
        PH_TAIL      = 4'd2,
        PH_BLOCK_END = 4'd3,
        PH_PULSE_0   = 4'd4,
        PH_PULSE_1   = 4'd5,
        PH_LOG_0     = 4'd6,
        PH_LOG_1     = 4'd7,
        PH_BYTE      = 4'd8,
        PH_BLOCK     = 4'd9
    } phase_t;

    phase_t                          phase_reg, phase_next;
    phase_t                          ret_reg, ret_next;
    logic [tpwe_pkg::ACC_W-1:0]      acc_reg, acc_next;
    logic [tpwe_pkg::TGT_W-1:0]      target_reg, target_next;
    logic [tpwe_pkg::COUNT_W-1:0]    count_reg, count_next;
    logic                            unarmed_reg, unarmed_next;
    logic [7:0]                      shift_reg, shift_next;
    logic [15:0]                     remain_reg, remain_next;
    logic                            header_reg, header_next;
    logic                            level_reg, level_next;
    tpwe_pkg::result_t               result_reg, result_next;

    logic [tpwe_pkg::ACC_W:0]        acc_sum;
    logic [tpwe_pkg::ACC_W-1:0]      acc_sat;
    logic [tpwe_pkg::COUNT_W-1:0]    count_dec;
    logic                            pulse_done;
    logic                            taken, progress, request;

    assign acc_sum   = {1'b0, acc_reg} + {{(tpwe_pkg::ACC_W + 1 - tpwe_pkg::ELAP_W){1'b0}},
                                          item.elapsed_ticks};
    assign acc_sat   = acc_sum[tpwe_pkg::ACC_W] ? {tpwe_pkg::ACC_W{1'b1}}
                                                 : acc_sum[tpwe_pkg::ACC_W-1:0];
    assign pulse_done = acc_sat > {{(tpwe_pkg::ACC_W - tpwe_pkg::TGT_W){1'b0}}, target_reg};
    assign count_dec = count_reg - 1'b1;

    always_comb begin
        phase_next   = phase_reg;
        ret_next     = ret_reg;
        acc_next     = acc_reg;
        target_next  = target_reg;
        count_next   = count_reg;
        unarmed_next = unarmed_reg;
        shift_next   = shift_reg;
        remain_next  = remain_reg;
        header_next  = header_reg;
        level_next   = level_reg;
        taken        = 1'b0;
        progress     = 1'b0;
        request      = 1'b0;

        if (item.kind) begin
            remain_next = item.block_length;
            header_next = item.is_header;
            if (phase_reg == PH_IDLE) begin
                phase_next   = PH_LEADER;
                unarmed_next = 1'b1;
            end
        end else begin
            acc_next = acc_sat;
            unique case (phase_reg)
                PH_LEADER, PH_TAIL, PH_BLOCK_END: begin
                    if (unarmed_reg) begin
                        ret_next     = phase_reg;
                        count_next   = (phase_reg == PH_LEADER) ? cfg.leader_bit_count
                                                                : cfg.trailer_bit_count;
                        unarmed_next = 1'b0;
                        phase_next   = PH_LOG_0;
                    end else begin
                        count_next = count_dec;
                        if (count_dec == '0) begin
                            if (phase_reg == PH_LEADER) begin
                                progress     = 1'b1;
                                phase_next   = PH_BYTE;
                                shift_next   = tpwe_pkg::SYNC_BYTE;
                                unarmed_next = 1'b1;
                            end else if (phase_reg == PH_BLOCK_END) begin
                                request    = 1'b1;
                                phase_next = PH_IDLE;
                            end else begin
                                phase_next = PH_LOG_1;
                                ret_next   = PH_BLOCK;
                            end
                        end else begin
                            phase_next = PH_LOG_0;
                        end
                    end
                end
                PH_PULSE_0: begin
                    level_next = 1'b0;
                    if (pulse_done) begin
                        phase_next = ret_reg;
                    end
                end
                PH_PULSE_1: begin
                    level_next = 1'b1;
                    if (pulse_done) begin
                        phase_next  = PH_PULSE_0;
                        acc_next    = '0;
                        target_next = {1'b0, cfg.long_pulse_ticks};
                    end
                end
                PH_LOG_0: begin
                    phase_next  = PH_PULSE_1;
                    acc_next    = '0;
                    target_next = {1'b0, cfg.short_pulse_ticks};
                end
                PH_LOG_1: begin
                    phase_next  = PH_PULSE_1;
                    acc_next    = '0;
                    target_next = {1'b0, cfg.short_pulse_ticks} + {1'b0, cfg.long_pulse_ticks};
                end
                PH_BYTE: begin
                    if (unarmed_reg) begin
                        unarmed_next = 1'b0;
                        count_next   = tpwe_pkg::BYTE_BITS;
                        phase_next   = PH_LOG_1;
                        ret_next     = PH_BYTE;
                    end else begin
                        count_next = count_dec;
                        if (count_dec == '0) begin
                            progress   = 1'b1;
                            phase_next = PH_BLOCK;
                        end else begin
                            phase_next = shift_reg[0] ? PH_LOG_1 : PH_LOG_0;
                            shift_next = {1'b0, shift_reg[7:1]};
                        end
                    end
                end
                PH_BLOCK: begin
                    unarmed_next = 1'b1;
                    if (remain_reg == '0) begin
                        if (header_reg) begin
                            request    = 1'b1;
                            phase_next = PH_TAIL;
                        end else begin
                            phase_next = PH_BLOCK_END;
                        end
                    end else begin
                        phase_next  = PH_BYTE;
                        shift_next  = item.next_byte;
                        taken       = 1'b1;
                        remain_next = remain_reg - 1'b1;
                    end
                end
                default: begin
                    phase_next   = PH_IDLE;
                    level_next   = 1'b0;
                    acc_next     = '0;
                    unarmed_next = 1'b1;
                end
            endcase
        end

        result_next.tape_level         = level_next;
        result_next.byte_taken         = taken;
        result_next.progress_pulse     = progress;
        result_next.next_block_request = request;
        result_next.busy_res           = (phase_next != PH_IDLE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            ret_reg     <= PH_IDLE;
            acc_reg     <= '0;
            target_reg  <= '0;
            count_reg   <= '0;
            unarmed_reg <= 1'b1;
            shift_reg   <= '0;
            remain_reg  <= '0;
            header_reg  <= 1'b0;
            level_reg   <= 1'b0;
        end else if (step_en) begin
            phase_reg   <= phase_next;
            ret_reg     <= ret_next;
            acc_reg     <= acc_next;
            target_reg  <= target_next;
            count_reg   <= count_next;
            unarmed_reg <= unarmed_next;
            shift_reg   <= shift_next;
            remain_reg  <= remain_next;
            header_reg  <= header_next;
            level_reg   <= level_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en) begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

### src/tape_pulse_width_encoder_top.sv
// top level of the tape pulse-width encoder: stream ports, config registers
// depends on tpwe_pkg and tpwe_core
//
//   channel   dir  payload                                      beats
//   s_*       in   tuser: kind; tdata: elapsed/byte/length/hdr   one per item
//   m_*       out  tdata: level/taken/progress/request/busy      one per item
//   cfg_*     in   index 0..3, 16-bit data                       write only
//
// one item per cycle unless stalled: the step is a single pass through the state logic
// into the result register, so a result appears the cycle after its beat.
// reset clears the walk state to idle and loads the default pulse lengths
// and bit counts. the input is stalled only while the result register is
// full and m_tready is low.
module tape_pulse_width_encoder_top (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // elapsed_ticks[11:0], next_byte[19:12],
                                   // block_length[35:20], is_header[36], zero fill
    input  logic        s_tuser,   // kind

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // tape_level[0], byte_taken[1], progress_pulse[2],
                                   // next_block_request[3], busy_res[4], zero fill

    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_wdata
);

    tpwe_pkg::cfg_t    cfg_reg;
    tpwe_pkg::item_t   item;
    tpwe_pkg::result_t result;
    logic              m_tvalid_reg;
    logic              step_en;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign step_en  = s_tvalid && s_tready;

    assign item.kind          = s_tuser;
    assign item.elapsed_ticks = s_tdata[11:0];
    assign item.next_byte     = s_tdata[19:12];
    assign item.block_length  = s_tdata[35:20];
    assign item.is_header     = s_tdata[36];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.short_pulse_ticks <= tpwe_pkg::SHORT_PULSE_RST;
            cfg_reg.long_pulse_ticks  <= tpwe_pkg::LONG_PULSE_RST;
            cfg_reg.leader_bit_count  <= tpwe_pkg::LEADER_BITS_RST;
            cfg_reg.trailer_bit_count <= tpwe_pkg::TRAILER_BITS_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                tpwe_pkg::CFG_SHORT_PULSE:  cfg_reg.short_pulse_ticks <= cfg_wdata;
                tpwe_pkg::CFG_LONG_PULSE:   cfg_reg.long_pulse_ticks  <= cfg_wdata;
                tpwe_pkg::CFG_LEADER_BITS:
                    cfg_reg.leader_bit_count  <= cfg_wdata[tpwe_pkg::COUNT_W-1:0];
                tpwe_pkg::CFG_TRAILER_BITS:
                    cfg_reg.trailer_bit_count <= cfg_wdata[tpwe_pkg::COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (step_en) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    tpwe_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (step_en),
        .item    (item),
        .cfg     (cfg_reg),
        .result  (result)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, result};

endmodule
